FILE: hw/rtl/crlfs_pkg.sv
// ----------------------------------------------------------------------------
// crlfs_pkg
// Shared codes, beat group type and stuffing functions for the CRLF stuffer.
// ----------------------------------------------------------------------------
package crlfs_pkg;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ESC  = 8'hDB;
    localparam logic [7:0] CH_CRLF = 8'hDC;
    localparam logic [7:0] CH_EESC = 8'hDD;

    // Up to three output beats produced by one input beat
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            last;
    } t_group;

    // Build the output beats for one input byte given the held-CR flag
    function automatic t_group f_stuff(input logic pend, input logic [7:0] b,
                                       input logic last);
        t_group     g;
        logic [1:0] k;
        g    = '0;
        k    = 2'd0;
        g.last = last;
        if (pend && (b == CH_LF)) begin
            g.bytes[0] = CH_ESC;
            g.bytes[1] = CH_CRLF;
            k          = 2'd2;
        end else begin
            // flush a held CR that did not start a pair
            if (pend) begin
                g.bytes[0] = CH_CR;
                k          = 2'd1;
            end
            if (b == CH_CR) begin
                if (last) begin
                    g.bytes[k] = CH_CR;
                    k          = k + 2'd1;
                end
            end else if (b == CH_ESC) begin
                g.bytes[k]        = CH_ESC;
                g.bytes[k + 2'd1] = CH_EESC;
                k                 = k + 2'd2;
            end else begin
                g.bytes[k] = b;
                k          = k + 2'd1;
            end
        end
        g.count = k;
        return g;
    endfunction

    // Held-CR flag after one input byte
    function automatic logic f_next_pending(input logic [7:0] b, input logic last);
        return (b == CH_CR) && !last;
    endfunction

endpackage

FILE: hw/rtl/crlfs_in_if.sv
// ----------------------------------------------------------------------------
// crlfs_in_if
// Raw byte channel into the stuffer.
// ----------------------------------------------------------------------------
interface crlfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/crlfs_out_if.sv
// ----------------------------------------------------------------------------
// crlfs_out_if
// Stuffed byte channel out of the stuffer.
// ----------------------------------------------------------------------------
interface crlfs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: hw/rtl/crlfs_in_stage.sv
// ----------------------------------------------------------------------------
// crlfs_in_stage
// Input register, held-CR state and stuffing decode into a beat group.
// ----------------------------------------------------------------------------
module crlfs_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  logic                i_grp_free,
    output logic                o_grp_load,
    output crlfs_pkg::t_group   o_grp
);
    import crlfs_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       r_pending_cr;
    logic       n_pending_cr;

    // Hand the registered beat on when the serializer has room
    assign o_grp_load   = r_valid && i_grp_free;
    assign o_ready      = !r_valid || o_grp_load;
    assign o_grp        = f_stuff(r_pending_cr, r_data, r_last);
    assign n_pending_cr = f_next_pending(r_data, r_last);

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    // Advance the held-CR flag as each beat is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_cr <= 1'b0;
        end else if (o_grp_load) begin
            r_pending_cr <= n_pending_cr;
        end
    end
endmodule

FILE: hw/rtl/crlfs_serializer.sv
// ----------------------------------------------------------------------------
// crlfs_serializer
// Result register holding one beat group and emitting it a beat per cycle while the output is ready.
// ----------------------------------------------------------------------------
module crlfs_serializer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_grp_load,
    input  crlfs_pkg::t_group   i_grp,
    output logic                o_grp_free,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_out_last
);
    import crlfs_pkg::*;

    logic [2:0][7:0] r_bytes;
    logic [1:0]      r_cnt;
    logic [1:0]      r_idx;
    logic            r_last;
    logic            w_take;
    logic            w_final;

    assign o_valid    = (r_cnt != 2'd0);
    assign w_take     = o_valid && i_ready;
    assign w_final    = (r_idx == (r_cnt - 2'd1));
    assign o_grp_free = !o_valid || (w_take && w_final);
    assign o_out_byte = r_bytes[r_idx];
    assign o_out_last = r_last && w_final;

    // Load a new group, step through it, drop it after its final beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_grp_load) begin
            r_cnt <= i_grp.count;
            r_idx <= 2'd0;
        end else if (w_take && w_final) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (w_take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grp_load) begin
            r_bytes <= i_grp.bytes;
            r_last  <= i_grp.last;
        end
    end
endmodule

FILE: hw/rtl/crlf_byte_stuffer.sv
// Path: an accepted input beat goes through the input register, then the
// serializer register. Throughput: one input beat per cycle while the output
// is ready; an escape (DB DD, DB DC) or a flushed CR ahead of a byte holds
// the input while the serializer emits extra beats, one output beat per cycle.
// Reset: synchronous active-low; clears the held-CR flag and both stages.
// ----------------------------------------------------------------------------
// crlf_byte_stuffer
// Escapes a byte stream for a CRLF-terminated serial link.
// ----------------------------------------------------------------------------
module crlf_byte_stuffer (
    input  logic   i_clk,
    input  logic   i_rst_n,
    crlfs_in_if.sink    i_in_ch,
    crlfs_out_if.source o_out_ch
);
    import crlfs_pkg::*;

    t_group w_grp;
    logic   w_grp_load;
    logic   w_grp_free;

    // Register and decode the input beat
    crlfs_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_ch.valid),
        .o_ready     (i_in_ch.ready),
        .i_data_byte (i_in_ch.data_byte),
        .i_last_byte (i_in_ch.last_byte),
        .i_grp_free  (w_grp_free),
        .o_grp_load  (w_grp_load),
        .o_grp       (w_grp)
    );

    // Emit the stuffed beats
    crlfs_serializer u_serializer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_grp_load (w_grp_load),
        .i_grp      (w_grp),
        .o_grp_free (w_grp_free),
        .o_valid    (o_out_ch.valid),
        .i_ready    (o_out_ch.ready),
        .o_out_byte (o_out_ch.out_byte),
        .o_out_last (o_out_ch.out_last)
    );
endmodule
